@@ hdl/aapr_pkg.sv @@
// Package for the axis-angle point rotation block: widths, fixed-point constants,
// register indexes, setup sequencer states and the matrix bundle type.
// No dependencies.
`timescale 1ns / 1ps

package aapr_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int ANGLE_WIDTH = 20;
  localparam int ADDR_WIDTH  = 8;
  localparam int MAT_WIDTH   = 34;
  localparam int QW          = 36;

  localparam logic signed [QW-1:0] Q_ONE     = 36'sd1073741824;
  localparam logic signed [QW-1:0] PI30      = 36'sd3373259426;
  localparam logic signed [QW-1:0] TWO_PI30  = 36'sd6746518852;
  localparam logic signed [QW-1:0] HALF_PI30 = 36'sd1686629713;

  typedef enum logic [ADDR_WIDTH-1:0] {
    REG_AXIS_X    = 8'd0,
    REG_AXIS_Y    = 8'd1,
    REG_AXIS_Z    = 8'd2,
    REG_ROT_ANGLE = 8'd3
  } aapr_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_NORM, ST_SQ, ST_SQRT, ST_UDIV, ST_ANG, ST_X2,
    ST_SER, ST_SN, ST_DIV, ST_MMUL, ST_MBUILD
  } aapr_state_t;

  typedef struct packed {
    logic                        busy;
    logic                        err;
    logic signed [MAT_WIDTH-1:0] m00, m01, m02;
    logic signed [MAT_WIDTH-1:0] m10, m11, m12;
    logic signed [MAT_WIDTH-1:0] m20, m21, m22;
  } aapr_mat_t;

  // Divisors of the Horner series: sine steps first, cosine steps after.
  function automatic logic [7:0] ser_div(input logic [3:0] step);
    logic [7:0] d;
    case (step)
      4'd0:    d = 8'd210;
      4'd1:    d = 8'd156;
      4'd2:    d = 8'd110;
      4'd3:    d = 8'd72;
      4'd4:    d = 8'd42;
      4'd5:    d = 8'd20;
      4'd6:    d = 8'd6;
      4'd7:    d = 8'd240;
      4'd8:    d = 8'd182;
      4'd9:    d = 8'd132;
      4'd10:   d = 8'd90;
      4'd11:   d = 8'd56;
      4'd12:   d = 8'd30;
      4'd13:   d = 8'd12;
      4'd14:   d = 8'd2;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // Reciprocal of each series divisor: ceil(2^(32+l) / d) - 2^32, l = ceil(log2(d)).
  function automatic logic [31:0] ser_recip(input logic [3:0] step);
    logic [31:0] r;
    case (step)
      4'd0:    r = 32'd940802361;
      4'd1:    r = 32'd2753184165;
      4'd2:    r = 32'd702812831;
      4'd3:    r = 32'd3340530120;
      4'd4:    r = 32'd2249744775;
      4'd5:    r = 32'd2576980378;
      4'd6:    r = 32'd1431655766;
      4'd7:    r = 32'd286331154;
      4'd8:    r = 32'd1746305385;
      4'd9:    r = 32'd4034666248;
      4'd10:   r = 32'd1813430637;
      4'd11:   r = 32'd613566757;
      4'd12:   r = 32'd286331154;
      4'd13:   r = 32'd1431655766;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] ser_shift(input logic [3:0] step);
    logic [3:0] l;
    case (step)
      4'd0:    l = 4'd8;
      4'd1:    l = 4'd8;
      4'd2:    l = 4'd7;
      4'd3:    l = 4'd7;
      4'd4:    l = 4'd6;
      4'd5:    l = 4'd5;
      4'd6:    l = 4'd3;
      4'd7:    l = 4'd8;
      4'd8:    l = 4'd8;
      4'd9:    l = 4'd8;
      4'd10:   l = 4'd7;
      4'd11:   l = 4'd6;
      4'd12:   l = 4'd5;
      4'd13:   l = 4'd4;
      4'd14:   l = 4'd1;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] a;
    a = (v < 0) ? -v : v;
    return a[31:0];
  endfunction

endpackage

@@ hdl/aapr_in_if.sv @@
// Input point channel: valid/ready handshake with the three point coordinates.
// Depends on aapr_pkg.
`timescale 1ns / 1ps

interface aapr_in_if import aapr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

@@ hdl/aapr_out_if.sv @@
// Result channel: valid/ready handshake with the rotated point and the axis error flag.
// Depends on aapr_pkg.
`timescale 1ns / 1ps

interface aapr_out_if import aapr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rotated_x;
  logic signed [COORD_WIDTH-1:0] rotated_y;
  logic signed [COORD_WIDTH-1:0] rotated_z;
  logic                          axis_error;

  modport source (output valid, rotated_x, rotated_y, rotated_z, axis_error, input ready);
  modport sink   (input valid, rotated_x, rotated_y, rotated_z, axis_error, output ready);
endinterface

@@ hdl/aapr_cfg_if.sv @@
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on aapr_pkg.
`timescale 1ns / 1ps

interface aapr_cfg_if import aapr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [ADDR_WIDTH-1:0]         addr;
  logic [COORD_WIDTH-1:0]        data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ hdl/axis_angle_point_rotation.sv @@
// Rotates one Q16.16 point per transaction about a configured axis by a configured angle.
// After reset and after every register write, the rotation matrix is rebuilt by a
// sequential setup engine (shared multiplier, bit-serial square root and axis divider,
// reciprocal multiplication for the series divisions), during which no point is
// accepted; the setup includes three 64-step axis divisions, the square root and the
// axis normalizing shifts, and a zero-length axis ends it at the normalizing step. Once
// built, points stream at one per cycle, while the output is not stalled, through a
// four-stage pipeline (capture, multiply, sum, round and saturate). A zero-length axis
// yields zero coordinates with axis_error set. Depends on aapr_pkg, the channel
// interfaces and aapr_setup.
`timescale 1ns / 1ps

module axis_angle_point_rotation import aapr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  aapr_in_if.sink     in_ch,
  aapr_out_if.source  out_ch,
  aapr_cfg_if.sink    cfg_ch
);

  localparam int PW = COORD_WIDTH + MAT_WIDTH;
  localparam int SW = PW + 2;
  localparam int RW = SW - 30;

  aapr_mat_t mat;

  logic                          en;
  logic                          v1_r, v2_r, v3_r, out_valid_r;
  logic signed [COORD_WIDTH-1:0] p_r [3];
  logic signed [PW-1:0]          pr_r [3][3];
  logic signed [SW-1:0]          sum_r [3];
  logic signed [RW-1:0]          sh [3];
  logic signed [COORD_WIDTH-1:0] res [3];
  logic signed [COORD_WIDTH-1:0] rx_r, ry_r, rz_r;
  logic                          err_r;
  logic signed [MAT_WIDTH-1:0]   m [3][3];

  localparam logic signed [RW-1:0] SAT_MAX = RW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_MIN = RW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

  aapr_setup u_setup (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .mat    (mat)
  );

  assign m[0][0] = mat.m00;
  assign m[0][1] = mat.m01;
  assign m[0][2] = mat.m02;
  assign m[1][0] = mat.m10;
  assign m[1][1] = mat.m11;
  assign m[1][2] = mat.m12;
  assign m[2][0] = mat.m20;
  assign m[2][1] = mat.m21;
  assign m[2][2] = mat.m22;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en && !mat.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_ch.valid && in_ch.ready;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh[r] = RW'(sum_r[r] >>> 30);
      if (sh[r] > SAT_MAX) begin
        res[r] = SAT_MAX[COORD_WIDTH-1:0];
      end else if (sh[r] < SAT_MIN) begin
        res[r] = SAT_MIN[COORD_WIDTH-1:0];
      end else begin
        res[r] = sh[r][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= in_ch.point_x;
      p_r[1] <= in_ch.point_y;
      p_r[2] <= in_ch.point_z;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pr_r[r][c] <= p_r[c] * m[r][c];
        end
        sum_r[r] <= SW'(pr_r[r][0]) + SW'(pr_r[r][1]) + SW'(pr_r[r][2])
                    + SW'(64'sd536870912);
      end
      err_r <= mat.err;
      rx_r  <= mat.err ? '0 : res[0];
      ry_r  <= mat.err ? '0 : res[1];
      rz_r  <= mat.err ? '0 : res[2];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.rotated_x  = rx_r;
  assign out_ch.rotated_y  = ry_r;
  assign out_ch.rotated_z  = rz_r;
  assign out_ch.axis_error = err_r;

endmodule

@@ hdl/aapr_setup.sv @@
// Configuration registers and the sequential engine that builds the rotation matrix:
// axis normalization, square root, division, sin/cos series and matrix products.
// Depends on aapr_pkg and aapr_cfg_if.
`timescale 1ns / 1ps

module aapr_setup import aapr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  aapr_cfg_if.sink    cfg_ch,
  output aapr_mat_t   mat
);

  logic signed [COORD_WIDTH-1:0] axis_x_r, axis_y_r, axis_z_r;
  logic signed [ANGLE_WIDTH-1:0] rot_angle_r;

  aapr_state_t state_r, state_nxt, ret_r;
  logic [31:0]          mg_r [3];
  logic                 sgn_r [3];
  logic [63:0]          acc_r, root_r, bit_r;
  logic [6:0]           cnt_r;
  logic [3:0]           step_r;
  logic [1:0]           ph_r;
  logic signed [QW-1:0] u_r [3];
  logic signed [QW-1:0] ang_r, x_r, x2_r, t_r, sn_r, cs_r;
  logic                 negc_r;
  logic [63:0]          prod_r;
  logic                 pneg_r;
  logic [63:0]          div_n_r;
  logic [31:0]          div_rem_r, div_d_r;
  logic                 dsgn_r;
  logic signed [QW-1:0] mres_r [15];
  logic                 err_r;
  logic signed [MAT_WIDTH-1:0] m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;

  logic                 cfg_wr;
  logic                 ax_zero, ax_big, ax_small;
  logic signed [QW-1:0] mul_a, mul_b, oc, mulq_res, quo, quo_s;
  logic [64:0]          rnd;
  logic [32:0]          rem_s;
  logic                 rem_ge;
  logic [63:0]          sq_try;
  logic [59:0]          sq;
  logic [7:0]           dcon;
  logic [31:0]          rcp;
  logic [3:0]           rsh;
  logic [32:0]          ser_sum;
  logic signed [QW-1:0] ser_q, ser_q_s;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r    <= '0;
      axis_y_r    <= '0;
      axis_z_r    <= 32'sd65536;
      rot_angle_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_ch.addr)
        REG_AXIS_X:    axis_x_r    <= cfg_ch.data;
        REG_AXIS_Y:    axis_y_r    <= cfg_ch.data;
        REG_AXIS_Z:    axis_z_r    <= cfg_ch.data;
        REG_ROT_ANGLE: rot_angle_r <= cfg_ch.data[ANGLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign ax_zero  = (mg_r[0] == '0) && (mg_r[1] == '0) && (mg_r[2] == '0);
  assign ax_big   = (|mg_r[0][31:30]) || (|mg_r[1][31:30]) || (|mg_r[2][31:30]);
  assign ax_small = !(|mg_r[0][31:29]) && !(|mg_r[1][31:29]) && !(|mg_r[2][31:29]);

  assign oc = Q_ONE - cs_r;

  always_comb begin
    mul_a = x_r;
    mul_b = x_r;
    case (state_r)
      ST_SER: begin
        if (ph_r == 2'd2) begin
          mul_a = QW'(div_n_r[31:0]);
          mul_b = QW'(rcp);
        end else begin
          mul_a = x2_r;
          mul_b = t_r;
        end
      end
      ST_SN: begin
        mul_a = x_r;
        mul_b = t_r;
      end
      ST_MMUL: begin
        case (step_r)
          4'd0:    begin mul_a = u_r[0];              mul_b = u_r[0]; end
          4'd1:    begin mul_a = u_r[1];              mul_b = u_r[1]; end
          4'd2:    begin mul_a = u_r[2];              mul_b = u_r[2]; end
          4'd3:    begin mul_a = u_r[0];              mul_b = u_r[1]; end
          4'd4:    begin mul_a = u_r[0];              mul_b = u_r[2]; end
          4'd5:    begin mul_a = u_r[1];              mul_b = u_r[2]; end
          4'd6:    begin mul_a = Q_ONE - mres_r[0];   mul_b = cs_r;   end
          4'd7:    begin mul_a = Q_ONE - mres_r[1];   mul_b = cs_r;   end
          4'd8:    begin mul_a = Q_ONE - mres_r[2];   mul_b = cs_r;   end
          4'd9:    begin mul_a = mres_r[3];           mul_b = oc;     end
          4'd10:   begin mul_a = mres_r[4];           mul_b = oc;     end
          4'd11:   begin mul_a = mres_r[5];           mul_b = oc;     end
          4'd12:   begin mul_a = u_r[2];              mul_b = sn_r;   end
          4'd13:   begin mul_a = u_r[1];              mul_b = sn_r;   end
          default: begin mul_a = u_r[0];              mul_b = sn_r;   end
        endcase
      end
      default: ;
    endcase
  end

  assign rnd      = {1'b0, prod_r} + 65'd536870912;
  assign mulq_res = pneg_r ? -QW'($signed({1'b0, rnd[64:30]})) : QW'($signed({1'b0, rnd[64:30]}));

  assign rem_s  = {div_rem_r, div_n_r[63]};
  assign rem_ge = rem_s >= {1'b0, div_d_r};
  assign quo    = QW'($signed({1'b0, div_n_r[34:0]}));
  assign quo_s  = dsgn_r ? -quo : quo;

  assign sq_try = root_r + bit_r;
  assign sq     = mg_r[step_r[1:0]][29:0] * mg_r[step_r[1:0]][29:0];
  assign dcon   = ser_div(step_r);
  assign rcp    = ser_recip(step_r);
  assign rsh    = ser_shift(step_r);

  assign ser_sum = {1'b0, div_n_r[31:0]} + {1'b0, prod_r[63:32]};
  assign ser_q   = QW'(ser_sum >> rsh);
  assign ser_q_s = dsgn_r ? -ser_q : ser_q;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   state_nxt = ST_IDLE;
      ST_LOAD:   state_nxt = ST_NORM;
      ST_NORM: begin
        if (ax_zero) begin
          state_nxt = ST_IDLE;
        end else if (!ax_big && !ax_small) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ:     if (step_r == 4'd2) state_nxt = ST_SQRT;
      ST_SQRT:   if (cnt_r == 7'd31) state_nxt = ST_UDIV;
      ST_UDIV: begin
        if (ph_r == 2'd0) begin
          state_nxt = ST_DIV;
        end else if (step_r == 4'd2) begin
          state_nxt = ST_ANG;
        end
      end
      ST_ANG:    if (ang_r <= PI30 && ang_r > -PI30) state_nxt = ST_X2;
      ST_X2:     if (ph_r == 2'd1) state_nxt = ST_SER;
      ST_SER: begin
        if (ph_r == 2'd3 && step_r == 4'd6) begin
          state_nxt = ST_SN;
        end else if (ph_r == 2'd3 && step_r == 4'd14) begin
          state_nxt = ST_MMUL;
        end
      end
      ST_SN:     if (ph_r == 2'd1) state_nxt = ST_SER;
      ST_DIV:    if (cnt_r == 7'd63) state_nxt = ret_r;
      ST_MMUL:   if (ph_r == 2'd1 && step_r == 4'd14) state_nxt = ST_MBUILD;
      ST_MBUILD: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    if (cfg_wr) begin
      state_nxt = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_NORM && ax_zero) begin
        err_r <= 1'b1;
      end else if (state_r == ST_MBUILD) begin
        err_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r != ST_DIV) begin
      prod_r <= mag32(mul_a) * mag32(mul_b);
      pneg_r <= (mul_a < 0) != (mul_b < 0);
    end
    case (state_r)
      ST_LOAD: begin
        mg_r[0]  <= mag32(QW'(axis_x_r));
        mg_r[1]  <= mag32(QW'(axis_y_r));
        mg_r[2]  <= mag32(QW'(axis_z_r));
        sgn_r[0] <= axis_x_r < 0;
        sgn_r[1] <= axis_y_r < 0;
        sgn_r[2] <= axis_z_r < 0;
        ang_r    <= QW'(rot_angle_r) <<< 14;
        acc_r    <= '0;
        step_r   <= '0;
        ph_r     <= '0;
      end
      ST_NORM: begin
        if (ax_big) begin
          for (int i = 0; i < 3; i++) mg_r[i] <= mg_r[i] >> 1;
        end else if (ax_small) begin
          for (int i = 0; i < 3; i++) mg_r[i] <= mg_r[i] << 1;
        end
      end
      ST_SQ: begin
        acc_r  <= acc_r + 64'(sq);
        step_r <= step_r + 4'd1;
        root_r <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        cnt_r  <= '0;
      end
      ST_SQRT: begin
        if (acc_r >= sq_try) begin
          acc_r  <= acc_r - sq_try;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        cnt_r  <= cnt_r + 7'd1;
        step_r <= '0;
        ph_r   <= '0;
      end
      ST_UDIV: begin
        if (ph_r == 2'd0) begin
          div_n_r   <= {4'b0000, mg_r[step_r[1:0]][29:0], 30'd0} + 64'(root_r[31:1]);
          div_d_r   <= root_r[31:0];
          div_rem_r <= '0;
          dsgn_r    <= sgn_r[step_r[1:0]];
          cnt_r     <= '0;
          ret_r     <= ST_UDIV;
          ph_r      <= 2'd1;
        end else begin
          u_r[step_r[1:0]] <= quo_s;
          step_r <= step_r + 4'd1;
          ph_r   <= '0;
        end
      end
      ST_ANG: begin
        if (ang_r > PI30) begin
          ang_r <= ang_r - TWO_PI30;
        end else if (ang_r <= -PI30) begin
          ang_r <= ang_r + TWO_PI30;
        end else if (ang_r > HALF_PI30) begin
          x_r    <= PI30 - ang_r;
          negc_r <= 1'b1;
        end else if (ang_r < -HALF_PI30) begin
          x_r    <= -PI30 - ang_r;
          negc_r <= 1'b1;
        end else begin
          x_r    <= ang_r;
          negc_r <= 1'b0;
        end
        ph_r <= '0;
      end
      ST_X2: begin
        if (ph_r == 2'd0) begin
          ph_r <= 2'd1;
        end else begin
          x2_r   <= mulq_res;
          t_r    <= Q_ONE;
          step_r <= '0;
          ph_r   <= '0;
        end
      end
      ST_SER: begin
        case (ph_r)
          2'd0: ph_r <= 2'd1;
          2'd1: begin
            div_n_r <= 64'(mag32(mulq_res)) + 64'(dcon[7:1]);
            dsgn_r  <= mulq_res < 0;
            ph_r    <= 2'd2;
          end
          2'd2: ph_r <= 2'd3;
          default: begin
            t_r  <= Q_ONE - ser_q_s;
            ph_r <= '0;
            if (step_r == 4'd14) begin
              cs_r   <= negc_r ? ser_q_s - Q_ONE : Q_ONE - ser_q_s;
              step_r <= '0;
            end else begin
              step_r <= step_r + 4'd1;
            end
          end
        endcase
      end
      ST_SN: begin
        if (ph_r == 2'd0) begin
          ph_r <= 2'd1;
        end else begin
          sn_r   <= mulq_res;
          t_r    <= Q_ONE;
          step_r <= 4'd7;
          ph_r   <= '0;
        end
      end
      ST_DIV: begin
        if (rem_ge) begin
          div_rem_r <= 32'(rem_s - {1'b0, div_d_r});
        end else begin
          div_rem_r <= rem_s[31:0];
        end
        div_n_r <= {div_n_r[62:0], rem_ge};
        cnt_r   <= cnt_r + 7'd1;
      end
      ST_MMUL: begin
        if (ph_r == 2'd0) begin
          ph_r <= 2'd1;
        end else begin
          mres_r[step_r] <= mulq_res;
          step_r <= step_r + 4'd1;
          ph_r   <= '0;
        end
      end
      ST_MBUILD: begin
        m00_r <= MAT_WIDTH'(mres_r[0] + mres_r[6]);
        m01_r <= MAT_WIDTH'(mres_r[9] - mres_r[12]);
        m02_r <= MAT_WIDTH'(mres_r[10] + mres_r[13]);
        m10_r <= MAT_WIDTH'(mres_r[9] + mres_r[12]);
        m11_r <= MAT_WIDTH'(mres_r[1] + mres_r[7]);
        m12_r <= MAT_WIDTH'(mres_r[11] - mres_r[14]);
        m20_r <= MAT_WIDTH'(mres_r[10] - mres_r[13]);
        m21_r <= MAT_WIDTH'(mres_r[11] + mres_r[14]);
        m22_r <= MAT_WIDTH'(mres_r[2] + mres_r[8]);
      end
      default: ;
    endcase
  end

  always_comb begin
    mat.busy = state_r != ST_IDLE;
    mat.err  = err_r;
    mat.m00  = m00_r;
    mat.m01  = m01_r;
    mat.m02  = m02_r;
    mat.m10  = m10_r;
    mat.m11  = m11_r;
    mat.m12  = m12_r;
    mat.m20  = m20_r;
    mat.m21  = m21_r;
    mat.m22  = m22_r;
  end

endmodule
